// File: sv/drs_pkg.sv
// drs_pkg: shared constants, codes and control structs of the disk request scheduler
// used by drs_ctrl, drs_datapath and disk_request_scheduler; no dependencies
package drs_pkg;

   localparam int SLOTS      = 64;
   localparam int TRACK_BITS = 16;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);

   // fixed field widths of the stream payload
   localparam int SLOT_W  = 6;
   localparam int TRACK_W = 16;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 32;

   localparam logic [1:0] MODE_FIFO = 2'd0;
   localparam logic [1:0] MODE_SSTF = 2'd1;
   localparam logic [1:0] MODE_LOOK = 2'd2;

   localparam logic KIND_ENQ  = 1'b0;
   localparam logic KIND_PICK = 1'b1;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [TRACK_BITS-1:0] track_type;

   localparam slot_type LAST_SLOT = SLOT_BITS'(SLOTS - 1);

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [TRACK_W-1:0] track;
      logic [TRACK_W-1:0] head;
   } drs_req_type;

   typedef struct packed {
      logic               grant_valid;
      logic [SLOT_W-1:0]  grant_slot;
      logic [TRACK_W-1:0] grant_track;
      logic               move_up;
      logic               store_empty;
      logic               enqueue_error;
   } drs_res_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic flip;
      logic fifo_slot;
      logic fifo_track;
      logic rm_start;
      logic rm_step;
      logic rm_end;
      logic commit;
   } drs_cmd_type;

   typedef struct packed {
      logic is_enq;
      logic empty;
      logic fifo;
      logic scan_last;
      logic need_flip;
      logic rm_last;
   } drs_stat_type;

endpackage

// File: sv/disk_request_scheduler.sv
// disk request scheduler: a store of 64 pending disk requests with a fifo, nearest-seek or
// elevator pick rule.
// channels: req_ takes one beat per item; req_tuser is the kind (0 enqueue, 1 pick) and
// req_tdata carries slot, request track and head track. rsp_ returns exactly one beat per
// item with grant, direction, empty and error flags. csr_wr_en writes the 2-bit mode
// (0 fifo, 1 nearest seek, 2 and 3 elevator), to be done while idle.
// operation: one item is in work at a time. an enqueue, an empty pick or a refused enqueue
// goes straight to its beat; a fifo pick reads the ring head and then that slot's track. a
// nearest-seek pick reads one track per slot over all 64 slots through the single
// comparator, then one arrival-ring entry per cycle over the pending requests to close the
// gap left by the chosen request. an elevator pick that reverses scans twice.
// reset clears the store, the ring pointers and the mode, sets the direction to up and
// needs no clearing pass; slot tracks and ring entries are only read once written.
// a result waits in the output register while rsp_tready is low, and the next beat is
// accepted meanwhile; a later result waits in the block until that register frees up.
module disk_request_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [5:0] request_slot, [21:6] request_track, [37:22] head_track, [39:38] zero
   input  logic [drs_pkg::REQ_W-1:0] req_tdata,
   // [0] kind
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] grant_valid, [6:1] grant_slot, [22:7] grant_track, [23] move_up,
   // [24] store_empty, [25] enqueue_error, [31:26] zero
   output logic [drs_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_wr_data
);
   import drs_pkg::*;

   drs_cmd_type  cmd;
   drs_stat_type stat;
   drs_req_type  req;
   drs_res_type  res;
   logic         idle, req_accept, out_free;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = idle;
   assign req_accept = req_tvalid && idle;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   always_comb begin
      req.kind  = req_tuser;
      req.slot  = req_tdata[SLOT_W-1:0];
      req.track = req_tdata[SLOT_W +: TRACK_W];
      req.head  = req_tdata[SLOT_W + TRACK_W +: TRACK_W];
   end

   drs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .out_free   (out_free),
      .stat       (stat),
      .cmd        (cmd),
      .idle       (idle)
   );

   drs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req),
      .cmd         (cmd),
      .stat        (stat),
      .res         (res)
   );

   // output register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = RSP_W'({res.enqueue_error, res.store_empty, res.move_up,
                               res.grant_track, res.grant_slot, res.grant_valid});
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/drs_ctrl.sv
// drs_ctrl: sequencer of the disk request scheduler
// drives drs_datapath through drs_cmd_type and reads back drs_stat_type; uses drs_pkg
module drs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 out_free,
   input  drs_pkg::drs_stat_type stat,
   output drs_pkg::drs_cmd_type  cmd,
   output logic                 idle
);
   import drs_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_DECIDE   = 10'b00_0000_0010,
      ST_FIFO_A   = 10'b00_0000_0100,
      ST_FIFO_B   = 10'b00_0000_1000,
      ST_SCAN     = 10'b00_0001_0000,
      ST_SCAN_END = 10'b00_0010_0000,
      ST_SCAN_CHK = 10'b00_0100_0000,
      ST_RM       = 10'b00_1000_0000,
      ST_RM_END   = 10'b01_0000_0000,
      ST_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.is_enq || stat.empty) begin
               state_in = ST_DONE;
            end else if (stat.fifo) begin
               // ring read at the head is issued in this cycle
               state_in = ST_FIFO_A;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_FIFO_A: begin
            cmd.fifo_slot = 1'b1;
            state_in      = ST_FIFO_B;
         end
         ST_FIFO_B: begin
            cmd.fifo_track = 1'b1;
            state_in       = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            // last compare lands here
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (stat.need_flip) begin
               cmd.flip = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.rm_start = 1'b1;
               state_in     = ST_RM;
            end
         end
         ST_RM: begin
            cmd.rm_step = 1'b1;
            if (stat.rm_last) begin
               state_in = ST_RM_END;
            end
         end
         ST_RM_END: begin
            cmd.rm_end = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// File: sv/drs_datapath.sv
// drs_datapath: request store, arrival ring, seek comparator and mode register
// commanded by drs_ctrl through drs_cmd_type; uses drs_pkg
module drs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data,
   input  drs_pkg::drs_req_type req,
   input  drs_pkg::drs_cmd_type cmd,
   output drs_pkg::drs_stat_type stat,
   output drs_pkg::drs_res_type res
);
   import drs_pkg::*;

   function automatic slot_type ptr_inc(input slot_type p);
      return (p == LAST_SLOT) ? '0 : p + SLOT_BITS'(1);
   endfunction

   function automatic slot_type ptr_dec(input slot_type p);
      return (p == '0) ? LAST_SLOT : p - SLOT_BITS'(1);
   endfunction

   // control state
   logic [1:0]       mode_ff, mode_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic             dir_ff, dir_in;
   slot_type         ring_head_ff, ring_head_in;
   slot_type         ring_tail_ff, ring_tail_in;
   cnt_type          count_ff, count_in;
   cnt_type          idx_ff, idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             best_found_ff, best_found_in;
   logic             rm_found_ff, rm_found_in;

   // payload
   logic               in_kind_ff, in_kind_in;
   logic [SLOT_W-1:0]  in_slot_ff, in_slot_in;
   track_type          in_track_ff, in_track_in;
   track_type          in_head_ff, in_head_in;
   slot_type           cmp_idx_ff, cmp_idx_in;
   slot_type           best_slot_ff, best_slot_in;
   track_type          best_track_ff, best_track_in;
   track_type          best_dist_ff, best_dist_in;
   slot_type           rd_ptr_ff, rd_ptr_in;
   slot_type           rd_at_ff, rd_at_in;
   slot_type           prev_at_ff, prev_at_in;

   // memories
   track_type trk_mem_ff [SLOTS];
   slot_type  ring_mem_ff [SLOTS];
   track_type trk_q_ff;
   slot_type  ring_q_ff;

   logic      trk_we, ring_we;
   slot_type  trk_waddr, trk_raddr, ring_waddr, ring_raddr;
   track_type trk_wdata;
   slot_type  ring_wdata;

   logic      is_fifo, is_sstf, is_look, is_enq, enq_err, pick_ok;
   slot_type  slot_idx;
   logic      t_ge, in_dir, take;
   track_type seek_gap;

   always_comb begin
      is_fifo  = (mode_ff == MODE_FIFO);
      is_sstf  = (mode_ff == MODE_SSTF);
      is_look  = !is_fifo && !is_sstf;
      is_enq   = (in_kind_ff == KIND_ENQ);
      slot_idx = SLOT_BITS'(in_slot_ff);
      enq_err  = (32'(in_slot_ff) >= SLOTS) || used_ff[slot_idx]
                 || (count_ff >= CNT_BITS'(SLOTS));
      pick_ok  = !is_enq && (count_ff != '0);

      // seek comparator on the slot read in the previous cycle
      t_ge     = (trk_q_ff >= in_head_ff);
      seek_gap = t_ge ? (trk_q_ff - in_head_ff) : (in_head_ff - trk_q_ff);
      in_dir   = !is_look || (dir_ff ? t_ge : (trk_q_ff <= in_head_ff));
      take     = cmp_vld_ff && in_dir && (!best_found_ff || (seek_gap < best_dist_ff));
   end

   always_comb begin
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      used_in       = used_ff;
      dir_in        = dir_ff;
      ring_head_in  = ring_head_ff;
      ring_tail_in  = ring_tail_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      rd_vld_in     = 1'b0;
      best_found_in = best_found_ff;
      rm_found_in   = rm_found_ff;
      in_kind_in    = in_kind_ff;
      in_slot_in    = in_slot_ff;
      in_track_in   = in_track_ff;
      in_head_in    = in_head_ff;
      cmp_idx_in    = cmp_idx_ff;
      best_slot_in  = best_slot_ff;
      best_track_in = best_track_ff;
      best_dist_in  = best_dist_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_at_in      = rd_at_ff;
      prev_at_in    = prev_at_ff;

      trk_we     = 1'b0;
      trk_waddr  = slot_idx;
      trk_wdata  = in_track_ff;
      trk_raddr  = cmd.scan_step ? idx_ff[SLOT_BITS-1:0] : ring_q_ff;
      ring_we    = 1'b0;
      ring_waddr = prev_at_ff;
      ring_wdata = ring_q_ff;
      ring_raddr = cmd.rm_step ? rd_ptr_ff : ring_head_ff;

      if (cmd.load) begin
         in_kind_in  = req.kind;
         in_slot_in  = req.slot;
         in_track_in = TRACK_BITS'(req.track);
         in_head_in  = TRACK_BITS'(req.head);
      end

      if (cmd.scan_start || cmd.flip) begin
         idx_in        = '0;
         best_found_in = 1'b0;
      end
      if (cmd.flip) begin
         dir_in = !dir_ff;
      end
      if (cmd.scan_step) begin
         idx_in     = idx_ff + CNT_BITS'(1);
         cmp_vld_in = used_ff[idx_ff[SLOT_BITS-1:0]];
         cmp_idx_in = idx_ff[SLOT_BITS-1:0];
      end
      if (take) begin
         best_found_in = 1'b1;
         best_slot_in  = cmp_idx_ff;
         best_track_in = trk_q_ff;
         best_dist_in  = seek_gap;
      end

      if (cmd.fifo_slot) begin
         best_slot_in = ring_q_ff;
         ring_head_in = ptr_inc(ring_head_ff);
      end
      if (cmd.fifo_track) begin
         best_track_in = trk_q_ff;
      end

      // ring removal: entries behind the chosen slot move one place forward
      if (cmd.rm_start) begin
         idx_in      = '0;
         rd_ptr_in   = ring_head_ff;
         rm_found_in = 1'b0;
      end
      if (cmd.rm_step) begin
         idx_in    = idx_ff + CNT_BITS'(1);
         rd_vld_in = 1'b1;
         rd_at_in  = rd_ptr_ff;
         rd_ptr_in = ptr_inc(rd_ptr_ff);
      end
      if (rd_vld_ff) begin
         prev_at_in = rd_at_ff;
         if (ring_q_ff == best_slot_ff) begin
            rm_found_in = 1'b1;
         end
         if (rm_found_ff) begin
            ring_we = 1'b1;
         end
      end
      if (cmd.rm_end) begin
         ring_tail_in = ptr_dec(ring_tail_ff);
      end

      if (cmd.commit) begin
         if (is_enq) begin
            if (!enq_err) begin
               used_in[slot_idx] = 1'b1;
               trk_we       = 1'b1;
               ring_we      = 1'b1;
               ring_waddr   = ring_tail_ff;
               ring_wdata   = slot_idx;
               ring_tail_in = ptr_inc(ring_tail_ff);
               count_in     = count_ff + CNT_BITS'(1);
            end
         end else if (pick_ok) begin
            used_in[best_slot_ff] = 1'b0;
            count_in = count_ff - CNT_BITS'(1);
            if (!is_look) begin
               if (best_track_ff > in_head_ff) begin
                  dir_in = 1'b1;
               end else if (best_track_ff < in_head_ff) begin
                  dir_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FIFO;
         used_ff       <= '0;
         dir_ff        <= 1'b1;
         ring_head_ff  <= '0;
         ring_tail_ff  <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rm_found_ff   <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         used_ff       <= used_in;
         dir_ff        <= dir_in;
         ring_head_ff  <= ring_head_in;
         ring_tail_ff  <= ring_tail_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         rm_found_ff   <= rm_found_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff    <= in_kind_in;
      in_slot_ff    <= in_slot_in;
      in_track_ff   <= in_track_in;
      in_head_ff    <= in_head_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_slot_ff  <= best_slot_in;
      best_track_ff <= best_track_in;
      best_dist_ff  <= best_dist_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_at_ff      <= rd_at_in;
      prev_at_ff    <= prev_at_in;
   end

   always_ff @(posedge clock) begin
      if (trk_we) begin
         trk_mem_ff[trk_waddr] <= trk_wdata;
      end
      trk_q_ff <= trk_mem_ff[trk_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem_ff[ring_waddr] <= ring_wdata;
      end
      ring_q_ff <= ring_mem_ff[ring_raddr];
   end

   always_comb begin
      stat.is_enq    = is_enq;
      stat.empty     = (count_ff == '0);
      stat.fifo      = is_fifo;
      stat.scan_last = (idx_ff == CNT_BITS'(SLOTS - 1));
      stat.need_flip = is_look && !best_found_ff;
      stat.rm_last   = (idx_ff == count_ff - CNT_BITS'(1));

      // read only in the commit cycle, after-item values
      res.grant_valid   = pick_ok;
      res.grant_slot    = pick_ok ? SLOT_W'(best_slot_ff) : '0;
      res.grant_track   = pick_ok ? TRACK_W'(best_track_ff) : '0;
      res.move_up       = dir_in;
      res.store_empty   = (count_in == '0);
      res.enqueue_error = is_enq && enq_err;
   end

endmodule

// File: tb/grant_book_pkg.sv
`timescale 1ns / 100ps
// grant_book_pkg: scoreboard class for the disk request scheduler bench. It keeps its own
// copy of the request store, predicts the response beat of each request and checks it.
// depends on drs_pkg
package grant_book_pkg;
   import drs_pkg::*;

   // the mode register's fourth code, handled as the elevator
   localparam logic [1:0] MODE_LOOK_ALT = 2'd3;

   typedef enum int {SIDE_ANY, SIDE_UP, SIDE_DOWN} seek_side_type;

   class grant_book;
      logic [1:0]  mode;
      bit          slot_busy [SLOTS];
      track_type   slot_track [SLOTS];
      slot_type    arrival [$];
      bit          dir_up;
      drs_res_type grants_due [$];
      int unsigned errors, requests, grants, refusals, empty_picks, reversals;

      function new();
         mode = MODE_FIFO;
         dir_up = 1'b1;
         foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_track[i] = '0;
         end
      endfunction

      function void set_mode(logic [1:0] m);
         mode = m;
      endfunction

      function int unsigned occupancy();
         return arrival.size();
      endfunction

      function int unsigned outstanding();
         return grants_due.size();
      endfunction

      function bit is_free(int s);
         return !slot_busy[s];
      endfunction

      function track_type some_pending_track();
         if (arrival.size() == 0) return '0;
         return slot_track[arrival[$urandom_range(0, arrival.size() - 1)]];
      endfunction

      // closest pending track on the given side, lowest slot wins a tie
      function int nearest_slot(track_type head, seek_side_type side);
         int          best;
         int unsigned best_dist, gap;
         best = -1;
         best_dist = 0;
         for (int s = 0; s < SLOTS; s++) begin
            if (!slot_busy[s]) continue;
            if (side == SIDE_UP && slot_track[s] < head) continue;
            if (side == SIDE_DOWN && slot_track[s] > head) continue;
            gap = 32'((slot_track[s] >= head) ? slot_track[s] - head : head - slot_track[s]);
            if (best < 0 || gap < best_dist) begin
               best = s;
               best_dist = gap;
            end
         end
         return best;
      endfunction

      function void file_request(drs_req_type r);
         drs_res_type want;
         int          pick, idx;
         want = '0;
         pick = -1;
         idx = -1;
         requests++;
         if (r.kind == KIND_ENQ) begin
            if (slot_busy[r.slot] || arrival.size() >= SLOTS) begin
               want.enqueue_error = 1'b1;
               refusals++;
            end else begin
               slot_busy[r.slot] = 1'b1;
               slot_track[r.slot] = r.track;
               arrival.push_back(r.slot);
            end
         end else if (arrival.size() == 0) begin
            empty_picks++;
         end else begin
            if (mode == MODE_FIFO) begin
               pick = int'(arrival.pop_front());
            end else begin
               if (mode == MODE_SSTF) begin
                  pick = nearest_slot(r.head, SIDE_ANY);
               end else begin
                  pick = nearest_slot(r.head, dir_up ? SIDE_UP : SIDE_DOWN);
                  if (pick < 0) begin
                     dir_up = !dir_up;
                     reversals++;
                     pick = nearest_slot(r.head, dir_up ? SIDE_UP : SIDE_DOWN);
                  end
               end
               // keep arrival order of what is left
               for (int k = 0; k < arrival.size(); k++)
                  if (idx < 0 && arrival[k] == pick) idx = k;
               if (idx >= 0) arrival.delete(idx);
            end
            want.grant_valid = 1'b1;
            want.grant_slot = SLOT_W'(pick);
            want.grant_track = slot_track[pick];
            slot_busy[pick] = 1'b0;
            grants++;
            if (mode == MODE_FIFO || mode == MODE_SSTF) begin
               if (want.grant_track > r.head) dir_up = 1'b1;
               else if (want.grant_track < r.head) dir_up = 1'b0;
            end
         end
         want.move_up = dir_up;
         want.store_empty = (arrival.size() == 0);
         grants_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void match_grant(logic [RSP_W-1:0] beat);
         drs_res_type got, want;
         got.grant_valid   = beat[0];
         got.grant_slot    = beat[6:1];
         got.grant_track   = beat[22:7];
         got.move_up       = beat[23];
         got.store_empty   = beat[24];
         got.enqueue_error = beat[25];
         if (grants_due.size() == 0) begin
            errors++;
            $display("%0t: response beat %h with no request waiting, expected none", $time, beat);
            return;
         end
         want = grants_due.pop_front();
         compare_field("grant_valid", 32'(want.grant_valid), 32'(got.grant_valid));
         compare_field("grant_slot", 32'(want.grant_slot), 32'(got.grant_slot));
         compare_field("grant_track", 32'(want.grant_track), 32'(got.grant_track));
         compare_field("move_up", 32'(want.move_up), 32'(got.move_up));
         compare_field("store_empty", 32'(want.store_empty), 32'(got.store_empty));
         compare_field("enqueue_error", 32'(want.enqueue_error), 32'(got.enqueue_error));
      endfunction
   endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: drives enqueue and pick beats into disk_request_scheduler under all four mode
// codes with random stalls on both sides and checks every response against grant_book.
// depends on drs_pkg, grant_book_pkg and the scheduler rtl
module testbench;
   import drs_pkg::*;
   import grant_book_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 85;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wr_en;
   logic [1:0]       csr_wr_data;

   grant_book book;
   bit        bursts_on;
   bit        long_hold_req;
   int        quiet = 0;

   disk_request_scheduler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: checks each beat, stalls in bursts and once for a long stretch
   initial begin : response_side
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) book.match_grant(rsp_tdata);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else
            rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("** disk_request_scheduler: FAILED **");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   task automatic send_item(logic kind, slot_type slot, track_type track, track_type head);
      drs_req_type r;
      r.kind  = kind;
      r.slot  = slot;
      r.track = track;
      r.head  = head;
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, head, track, slot};
      do @(posedge clock); while (!req_tready);
      book.file_request(r);
   endtask

   // the field that a kind does not use still carries random bits
   task automatic enqueue(slot_type s, track_type t);
      send_item(KIND_ENQ, s, t, track_type'($urandom_range(0, 65535)));
   endtask

   task automatic pick(track_type head);
      send_item(KIND_PICK, slot_type'($urandom_range(0, SLOTS - 1)),
                track_type'($urandom_range(0, 65535)), head);
   endtask

   task automatic write_mode(logic [1:0] m);
      req_tvalid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.set_mode(m);
   endtask

   // clusters give equal tracks and equal distances, so the tie rule gets exercised
   function automatic track_type rand_track();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1:       return track_type'(16'd1000 + $urandom_range(0, 15));
         2:       return track_type'(16'd30000 + $urandom_range(0, 7));
         3:       return track_type'(16'hFFF0 + $urandom_range(0, 15));
         default: return track_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_item(int enq_pct);
      int base, s;
      if ($urandom_range(0, 99) < enq_pct) begin
         base = $urandom_range(0, SLOTS - 1);
         s = base;
         // mostly aim at a free slot, sometimes at any slot
         if ($urandom_range(0, 4) != 0)
            for (int k = SLOTS - 1; k >= 0; k--)
               if (book.is_free((base + k) % SLOTS)) s = (base + k) % SLOTS;
         enqueue(slot_type'(s), rand_track());
      end else
         pick($urandom_range(0, 3) == 0 ? book.some_pending_track() : rand_track());
   endtask

   task automatic fill_store();
      int s;
      while (book.occupancy() < SLOTS) begin
         s = $urandom_range(0, SLOTS - 1);
         while (!book.is_free(s)) s = (s + 1) % SLOTS;
         enqueue(slot_type'(s), rand_track());
      end
      enqueue(slot_type'($urandom_range(0, SLOTS - 1)), rand_track());
   endtask

   function automatic logic [1:0] phase_mode(int ph);
      case (ph % 4)
         0:       return MODE_FIFO;
         1:       return MODE_SSTF;
         2:       return MODE_LOOK;
         default: return MODE_LOOK_ALT;
      endcase
   endfunction

   initial begin : stimulus
      book = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_ENQ;
      csr_wr_en = 1'b0;
      csr_wr_data = MODE_FIFO;
      bursts_on = 1'b0;
      long_hold_req = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fifo: empty pick, extremes, occupied slot
      write_mode(MODE_FIFO);
      pick(16'd0);
      enqueue(6'd0, 16'd0);
      enqueue(6'd63, 16'hFFFF);
      enqueue(6'd0, 16'd1234);
      enqueue(6'd5, 16'd100);
      pick(16'hFFFF);
      pick(16'd0);

      // nearest seek with requests left over from fifo, ties on both sides of the head
      write_mode(MODE_SSTF);
      enqueue(6'd6, 16'd100);
      enqueue(6'd10, 16'd90);
      enqueue(6'd11, 16'd110);
      pick(16'd100);
      pick(16'd100);
      pick(16'd100);

      // elevator: track on the head, reversal, then an empty pick
      write_mode(MODE_LOOK);
      enqueue(6'd20, 16'd500);
      enqueue(6'd21, 16'd300);
      enqueue(6'd22, 16'd300);
      pick(16'd400);
      pick(16'd300);
      pick(16'd300);
      pick(16'd100);
      pick(16'd0);

      write_mode(MODE_LOOK_ALT);
      enqueue(6'd1, 16'hFFFF);
      enqueue(6'd2, 16'd0);
      pick(16'hFFFF);
      pick(16'hFFFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_mode(phase_mode(ph));
         bursts_on = (ph < PHASES - 2) && (ph % 3 != 2);
         if (ph == 5) long_hold_req = 1'b1;
         if (ph % 5 == 2) fill_store();
         repeat (PHASE_ITEMS) random_item((ph % 2 == 0) ? 75 : 40);
      end

      req_tvalid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d requests in all four mode codes: %0d grants, %0d empty picks",
               book.requests, book.grants, book.empty_picks);
      $display("%0d refused enqueues, %0d elevator reversals, %0d mismatches",
               book.refusals, book.reversals, book.errors);
      if (book.errors == 0 && book.outstanding() == 0)
         $display("** disk_request_scheduler: PASSED **");
      else
         $display("** disk_request_scheduler: FAILED **");
      $finish;
   end

endmodule
